[rtl/core/rgbcf_pkg.sv]
`timescale 1ns / 1ps

package rgbcf_pkg;

    // Stream widths
    localparam int PIX_W       = 8;
    localparam int RGB_W       = 3 * PIX_W;
    localparam int COL_W       = 11;
    localparam int ROW_W       = 2;
    localparam int WEIGHT_W    = 16;
    localparam int MODE_W      = 3;

    // Configuration port
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_RED   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_GREEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_BLUE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PADDED_WIDTH = 3'd4;

    // Kernel select; codes above MODE_LAPLACE give a zero result
    localparam logic [MODE_W-1:0] MODE_MEAN     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_GAUSS    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_HIGHPASS = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LAPLACE  = 3'd3;

    localparam logic [COL_W-1:0] PADDED_WIDTH_RST = 11'd1026;
    localparam int               MAX_WIDTH_DEF    = 1024;

    // Kernel magnitude is at most 9 * 255
    localparam int MAG_W   = 12;
    localparam int PROD_W  = MAG_W + WEIGHT_W;
    localparam int SUM_W   = 14;

    // floor(v / 9) = (v * 7282) >> 16, exact for v below 32768
    localparam int                DIV9_SHIFT = 16;
    localparam int                RECIP_W    = 13;
    localparam logic [RECIP_W-1:0] DIV9_RECIP = 13'd7282;

    localparam int GRAY_MAX = 255;

endpackage

[rtl/core/rgbcf_pix_if.sv]
`timescale 1ns / 1ps

interface rgbcf_pix_if;
    logic                          valid;
    logic                          ready;
    logic [rgbcf_pkg::PIX_W-1:0]   red;
    logic [rgbcf_pkg::PIX_W-1:0]   green;
    logic [rgbcf_pkg::PIX_W-1:0]   blue;
    logic                          frame_start;

    modport source (output valid, red, green, blue, frame_start, input ready);
    modport sink   (input valid, red, green, blue, frame_start, output ready);
endinterface

[rtl/core/rgbcf_gray_if.sv]
`timescale 1ns / 1ps

interface rgbcf_gray_if;
    logic                          valid;
    logic                          ready;
    logic [rgbcf_pkg::PIX_W-1:0]   gray;
    logic                          row_end;

    modport source (output valid, gray, row_end, input ready);
    modport sink   (input valid, gray, row_end, output ready);
endinterface

[rtl/core/rgb_conv3x3_luma_filter.sv]
`timescale 1ns / 1ps

// Channel   | Dir | Payload                          | Handshake
// ----------+-----+----------------------------------+------------------------
// i_pix     | in  | red, green, blue, frame_start    | valid/ready
// o_gray    | out | gray, row_end                    | valid/ready
// i_cfg_*   | in  | index, data                      | write enable, no wait
//
// One pixel transaction per clock, sustained while o_gray is ready; a producing
// pixel moves stage by stage into the output register, others drop out after stage 1.
// Line stores: one read (at accept) and one write (stage 1) per clock, bypassed
// when both hit the same column. Synchronous active-low reset clears valids,
// counters, window and config, not the line stores. Back-pressure ripples stage
// by stage, so input is still taken while a result waits at o_gray.

module rgb_conv3x3_luma_filter #(
    parameter int MAX_WIDTH = rgbcf_pkg::MAX_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    rgbcf_pix_if.sink                         i_pix,
    rgbcf_gray_if.source                      o_gray,
    input  logic                              i_cfg_we,
    input  logic [rgbcf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rgbcf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int DEPTH = MAX_WIDTH + 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = rgbcf_pkg::PIX_W;
    localparam int RW    = rgbcf_pkg::RGB_W;
    localparam int CW    = rgbcf_pkg::COL_W;
    localparam int MW    = rgbcf_pkg::MAG_W;
    localparam int WW    = rgbcf_pkg::WEIGHT_W;
    localparam int PRW   = rgbcf_pkg::PROD_W;
    localparam int SW    = rgbcf_pkg::SUM_W;
    localparam int DW    = MW + rgbcf_pkg::RECIP_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [rgbcf_pkg::MODE_W-1:0] r_filter_mode;
    logic [WW-1:0]                r_weight [3];   // red, green, blue
    logic [CW-1:0]                r_padded_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_mode  <= rgbcf_pkg::MODE_MEAN;
            r_weight[0]    <= '0;
            r_weight[1]    <= '0;
            r_weight[2]    <= '0;
            r_padded_width <= rgbcf_pkg::PADDED_WIDTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rgbcf_pkg::CFG_FILTER_MODE:
                    r_filter_mode  <= i_cfg_data[rgbcf_pkg::MODE_W-1:0];
                rgbcf_pkg::CFG_WEIGHT_RED:   r_weight[0] <= i_cfg_data[WW-1:0];
                rgbcf_pkg::CFG_WEIGHT_GREEN: r_weight[1] <= i_cfg_data[WW-1:0];
                rgbcf_pkg::CFG_WEIGHT_BLUE:  r_weight[2] <= i_cfg_data[WW-1:0];
                rgbcf_pkg::CFG_PADDED_WIDTH: r_padded_width <= i_cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage valids and ready chain
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic r_prod1;
    logic rdy2, rdy3, rdy4, rdy5;
    logic s1_go, pix_rdy, pix_acc;

    assign rdy5    = !r_v5 || o_gray.ready;
    assign rdy4    = !r_v4 || rdy5;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    // pixels with no window leave stage 1 regardless of downstream
    assign s1_go   = r_v1 && (!r_prod1 || rdy2);
    assign pix_rdy = !r_v1 || s1_go;
    assign pix_acc = i_pix.valid && pix_rdy;

    assign i_pix.ready = pix_rdy;

    // ------------------------------------------------------------------
    // Raster position at accept
    // ------------------------------------------------------------------
    logic [CW-1:0]                r_col, n_col;
    logic [rgbcf_pkg::ROW_W-1:0]  r_row, n_row;
    logic [CW-1:0]                col0;
    logic [rgbcf_pkg::ROW_W-1:0]  row0;
    logic [CW-1:0]                w_sat;
    logic                         last0, prod0;
    logic [AW-1:0]                addr0;

    always_comb begin
        col0 = i_pix.frame_start ? '0 : r_col;
        row0 = i_pix.frame_start ? '0 : r_row;

        // row length limited to 3..DEPTH
        if (r_padded_width < CW'(3)) begin
            w_sat = CW'(3);
        end else if (32'(r_padded_width) > 32'(DEPTH)) begin
            w_sat = CW'(DEPTH);
        end else begin
            w_sat = r_padded_width;
        end

        last0 = (col0 >= (w_sat - CW'(1)));
        prod0 = row0[1] && (col0 >= CW'(2));

        if (32'(col0) >= 32'(DEPTH - 1)) begin
            addr0 = AW'(DEPTH - 1);
        end else begin
            addr0 = AW'(col0);
        end

        n_col = last0 ? '0 : (col0 + CW'(1));
        n_row = (last0 && !row0[1]) ? (row0 + 2'd1) : row0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (pix_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: line store read data, store write-back, window shift
    // ------------------------------------------------------------------
    logic [RW-1:0] r_line_upper  [DEPTH];
    logic [RW-1:0] r_line_middle [DEPTH];

    logic [RW-1:0] r_rd_up1, r_rd_mid1;
    logic [RW-1:0] r_px1;
    logic [AW-1:0] r_addr1;
    logic          r_last1;
    logic          r_fwd1;
    logic [RW-1:0] r_fwd_up1, r_fwd_mid1;
    logic [RW-1:0] eff_up1, eff_mid1;

    assign eff_up1  = r_fwd1 ? r_fwd_up1  : r_rd_up1;
    assign eff_mid1 = r_fwd1 ? r_fwd_mid1 : r_rd_mid1;

    // stage 1 rewrites its column every cycle it is held; values are stable
    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_rd_up1 <= r_line_upper[addr0];
        end
        if (r_v1) begin
            r_line_upper[r_addr1] <= eff_mid1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_rd_mid1 <= r_line_middle[addr0];
        end
        if (r_v1) begin
            r_line_middle[r_addr1] <= r_px1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (pix_rdy) begin
            r_v1 <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_px1      <= {i_pix.red, i_pix.green, i_pix.blue};
            r_addr1    <= addr0;
            r_last1    <= last0;
            r_prod1    <= prod0;
            // same column written this edge: the store read returns stale data
            r_fwd1     <= r_v1 && (r_addr1 == addr0);
            r_fwd_up1  <= eff_mid1;
            r_fwd_mid1 <= r_px1;
        end
    end

    logic [RW-1:0] r_win [9];
    logic [RW-1:0] n_win [9];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r*3]     = r_win[r*3 + 1];
            n_win[r*3 + 1] = r_win[r*3 + 2];
        end
        n_win[2] = eff_up1;
        n_win[5] = eff_mid1;
        n_win[8] = r_px1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else if (s1_go) begin
            r_win <= n_win;
        end
    end

    // ------------------------------------------------------------------
    // Kernel per channel on the updated window (into stage 2)
    // ------------------------------------------------------------------
    logic [PW-1:0]  k_px    [3][9];
    logic [MW-1:0]  k_sum   [3];
    logic [MW-1:0]  k_gauss [3];
    logic [MW-1:0]  k_neigh [3];
    logic [MW-1:0]  k_c9    [3];
    logic [MW-1:0]  k_c8    [3];
    logic [SW-1:0]  k_t     [3];
    logic [MW-1:0]  n_mag2  [3];
    logic           n_neg2  [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 9; k++) begin
                k_px[c][k] = n_win[k][(2 - c)*PW +: PW];
            end
            k_sum[c] = MW'(k_px[c][0]) + MW'(k_px[c][1]) + MW'(k_px[c][2])
                     + MW'(k_px[c][3]) + MW'(k_px[c][4]) + MW'(k_px[c][5])
                     + MW'(k_px[c][6]) + MW'(k_px[c][7]) + MW'(k_px[c][8]);
            k_gauss[c] = MW'(k_px[c][0]) + MW'(k_px[c][2])
                       + MW'(k_px[c][6]) + MW'(k_px[c][8])
                       + ((MW'(k_px[c][1]) + MW'(k_px[c][3])
                         + MW'(k_px[c][5]) + MW'(k_px[c][7])) << 1)
                       + (MW'(k_px[c][4]) << 2);
            k_neigh[c] = k_sum[c] - MW'(k_px[c][4]);
            k_c8[c]    = MW'(k_px[c][4]) << 3;
            k_c9[c]    = k_c8[c] + MW'(k_px[c][4]);
            k_t[c]     = '0;
            n_mag2[c]  = '0;
            n_neg2[c]  = 1'b0;

            unique case (r_filter_mode)
                rgbcf_pkg::MODE_MEAN: begin
                    n_mag2[c] = k_sum[c];
                end
                rgbcf_pkg::MODE_GAUSS: begin
                    n_mag2[c] = k_gauss[c] >> 4;
                end
                rgbcf_pkg::MODE_HIGHPASS: begin
                    k_t[c]    = SW'(k_c9[c]) - SW'(k_neigh[c]);
                    n_neg2[c] = k_t[c][SW-1];
                    n_mag2[c] = n_neg2[c] ? MW'(-k_t[c]) : MW'(k_t[c]);
                end
                rgbcf_pkg::MODE_LAPLACE: begin
                    k_t[c]    = SW'(k_neigh[c]) - SW'(k_c8[c]);
                    n_neg2[c] = k_t[c][SW-1];
                    n_mag2[c] = n_neg2[c] ? MW'(-k_t[c]) : MW'(k_t[c]);
                end
                default: ;  // unused modes: zero
            endcase
        end
    end

    logic [MW-1:0] r_mag2 [3];
    logic          r_neg2 [3];
    logic          r_div9_2;
    logic          r_last2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1 && r_prod1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_mag2   <= n_mag2;
            r_neg2   <= n_neg2;
            r_div9_2 <= (r_filter_mode == rgbcf_pkg::MODE_MEAN);
            r_last2  <= r_last1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: weight multiply
    // ------------------------------------------------------------------
    logic [PRW-1:0] r_prodw3 [3];
    logic           r_neg3   [3];
    logic           r_div9_3;
    logic           r_last3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rdy3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            for (int c = 0; c < 3; c++) begin
                r_prodw3[c] <= PRW'(r_mag2[c]) * PRW'(r_weight[c]);
            end
            r_neg3   <= r_neg2;
            r_div9_3 <= r_div9_2;
            r_last3  <= r_last2;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: drop fraction, divide by nine for the mean kernel
    // ------------------------------------------------------------------
    logic [MW-1:0] sc_int  [3];
    logic [DW-1:0] sc_recip[3];
    logic [MW-1:0] n_val4  [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sc_int[c]   = r_prodw3[c][PRW-1:WW];
            sc_recip[c] = DW'(sc_int[c]) * DW'(rgbcf_pkg::DIV9_RECIP);
            n_val4[c]   = r_div9_3 ? MW'(sc_recip[c] >> rgbcf_pkg::DIV9_SHIFT)
                                   : sc_int[c];
        end
    end

    logic [MW-1:0] r_val4 [3];
    logic          r_neg4 [3];
    logic          r_last4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (rdy4) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_val4  <= n_val4;
            r_neg4  <= r_neg3;
            r_last4 <= r_last3;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: signed channel sum, clamp, output register
    // ------------------------------------------------------------------
    logic signed [SW-1:0] ch_s [3];
    logic signed [SW-1:0] luma_sum;
    logic [PW-1:0]        n_gray5;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            ch_s[c] = r_neg4[c] ? -$signed(SW'(r_val4[c])) : $signed(SW'(r_val4[c]));
        end
        luma_sum = ch_s[0] + ch_s[1] + ch_s[2];
        if (luma_sum < 0) begin
            n_gray5 = '0;
        end else if (luma_sum > SW'(rgbcf_pkg::GRAY_MAX)) begin
            n_gray5 = PW'(rgbcf_pkg::GRAY_MAX);
        end else begin
            n_gray5 = luma_sum[PW-1:0];
        end
    end

    logic [PW-1:0] r_gray5;
    logic          r_row_end5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (rdy5) begin
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy5) begin
            r_gray5    <= n_gray5;
            r_row_end5 <= r_last4;
        end
    end

    assign o_gray.valid   = r_v5;
    assign o_gray.gray    = r_gray5;
    assign o_gray.row_end = r_row_end5;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

// Self-checking bench for the 3x3 RGB convolution / luma filter.
// A clocked driver feeds pixel transactions from a queue, a clocked monitor
// takes gray transactions and checks them against a scoreboard queue. The
// scoreboard is filled by a behavioural model of the line stores, window and
// kernels, which runs on every accepted pixel transaction.
module testbench;
    import rgbcf_pkg::*;

    localparam int STORE_DEPTH  = MAX_WIDTH_DEF + 2;
    localparam int MEAN_DIV     = 9 * 65536;  // mean kernel: sum * w / (9 * 2^16)
    localparam int IDLE_GAP     = 12;         // margin after the result path drains
    localparam int RANDOM_ITEMS = 320;
    localparam int CYCLE_LIMIT  = 400000;

    // Codes above the Laplacian select a zero result
    localparam logic [MODE_W-1:0] MODE_ZERO_LOW  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ZERO_HIGH = 3'd7;
    // Largest value the width register holds; saturates to the store depth
    localparam logic [COL_W-1:0]  WIDTH_OVER     = 11'd2047;

    typedef struct packed {
        logic [PIX_W-1:0] red, green, blue;
        logic             frame_start;
    } pixel_t;

    typedef struct packed {
        logic [PIX_W-1:0] gray;
        logic             row_end;
    } luma_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rgbcf_pix_if  pix_ch ();
    rgbcf_gray_if gray_ch ();

    rgb_conv3x3_luma_filter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (pix_ch),
        .o_gray      (gray_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Shadow copy of the register file, at reset values
    logic [MODE_W-1:0]   mode_reg  = MODE_MEAN;
    logic [WEIGHT_W-1:0] weight_reg [3] = '{default: '0};  // red, green, blue
    logic [COL_W-1:0]    width_reg = PADDED_WIDTH_RST;

    // Model state: line stores hold rows r-2 and r-1, window is row-major
    logic [RGB_W-1:0] upper_line  [STORE_DEPTH];
    logic [RGB_W-1:0] middle_line [STORE_DEPTH];
    logic [RGB_W-1:0] window_px   [9] = '{default: '0};
    logic [COL_W-1:0] col_pos = '0;
    logic [ROW_W-1:0] row_pos = '0;

    pixel_t pixel_queue   [$];
    luma_t  luma_expected [$];

    int src_idle_pct    = 0;
    int sink_stall_pct  = 0;
    int fail_count      = 0;
    int cycle_count     = 0;
    int pixels_in       = 0;
    int results_checked = 0;
    int settings_count  = 0;
    logic [7:0] modes_seen = '0;

    // ------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------

    // Width register is used saturated to 3..store depth
    function automatic int clamp_width(logic [COL_W-1:0] w);
        return (w < 3) ? 3 : (w > STORE_DEPTH) ? STORE_DEPTH : int'(w);
    endfunction

    // One channel through the selected kernel, scaled by its Q0.16 weight.
    // Signed kernels truncate the magnitude, so rounding is toward zero.
    function automatic int kernel_term(int sh, int w);
        int v [9];
        int s, c, g, t, mag, i, result;
        s = 0;
        for (i = 0; i < 9; i++) begin
            v[i] = int'(window_px[i][sh +: PIX_W]);
            s += v[i];
        end
        c = v[4];
        result = 0;
        case (mode_reg)
            MODE_MEAN: begin
                result = int'((longint'(s) * w) / MEAN_DIV);
            end
            MODE_GAUSS: begin
                g = v[0] + v[2] + v[6] + v[8] + 2 * (v[1] + v[3] + v[5] + v[7]) + 4 * c;
                result = int'((longint'(g >> 4) * w) >> 16);
            end
            MODE_HIGHPASS, MODE_LAPLACE: begin
                // highpass: 9C - neighbours; Laplacian: neighbours - 8C
                t = (mode_reg == MODE_HIGHPASS) ? 10 * c - s : s - 9 * c;
                mag = (t < 0) ? -t : t;
                result = int'((longint'(mag) * w) >> 16);
                if (t < 0) result = -result;
            end
            default: result = 0;
        endcase
        return result;
    endfunction

    // Advance the model by one accepted pixel; queue a result once the
    // window covers three rows and three columns
    function automatic void filter_pixel(pixel_t p);
        logic [RGB_W-1:0] px, up, mid;
        int   wid, c, total, r;
        logic last;
        luma_t res;
        px  = {p.red, p.green, p.blue};
        wid = clamp_width(width_reg);
        if (p.frame_start) begin
            col_pos = '0;
            row_pos = '0;
        end
        c    = int'(col_pos);
        // also catches a width narrowed mid-row: the row ends here
        last = (c >= wid - 1);
        if (c >= STORE_DEPTH) c = STORE_DEPTH - 1;

        up  = upper_line[c];
        mid = middle_line[c];
        upper_line[c]  = mid;
        middle_line[c] = px;

        for (r = 0; r < 3; r++) begin
            window_px[r * 3]     = window_px[r * 3 + 1];
            window_px[r * 3 + 1] = window_px[r * 3 + 2];
        end
        window_px[2] = up;
        window_px[5] = mid;
        window_px[8] = px;

        if (row_pos >= 2 && col_pos >= 2) begin
            total = kernel_term(16, int'(weight_reg[0]))
                  + kernel_term(8,  int'(weight_reg[1]))
                  + kernel_term(0,  int'(weight_reg[2]));
            if (total < 0)        total = 0;
            if (total > GRAY_MAX) total = GRAY_MAX;
            res.gray    = total[PIX_W-1:0];
            res.row_end = last;
            luma_expected.push_back(res);
        end

        if (last) begin
            col_pos = '0;
            if (row_pos < 2) row_pos = row_pos + 1'b1;
        end else begin
            col_pos = col_pos + 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, driver, monitor, watchdog
    // ------------------------------------------------------------------

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Pixel driver: a new transaction is offered once the previous one is
    // taken; the model sees each pixel at the edge it is accepted
    always @(posedge i_clk) begin : pixel_driver
        pixel_t nxt;
        if (!i_rst_n) begin
            pix_ch.valid <= 1'b0;
        end else begin
            if (pix_ch.valid && pix_ch.ready) begin
                nxt.red         = pix_ch.red;
                nxt.green       = pix_ch.green;
                nxt.blue        = pix_ch.blue;
                nxt.frame_start = pix_ch.frame_start;
                filter_pixel(nxt);
                pixels_in++;
            end
            if (!pix_ch.valid || pix_ch.ready) begin
                if (pixel_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    nxt = pixel_queue.pop_front();
                    pix_ch.valid       <= 1'b1;
                    pix_ch.red         <= nxt.red;
                    pix_ch.green       <= nxt.green;
                    pix_ch.blue        <= nxt.blue;
                    pix_ch.frame_start <= nxt.frame_start;
                end else begin
                    pix_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Gray monitor with random back-pressure
    always @(posedge i_clk) begin : gray_monitor
        luma_t want;
        if (!i_rst_n) begin
            gray_ch.ready <= 1'b0;
        end else begin
            if (gray_ch.valid && gray_ch.ready) begin
                if (luma_expected.size() == 0) begin
                    $error("gray transaction with none pending: gray=%0d row_end=%0b",
                           gray_ch.gray, gray_ch.row_end);
                    fail_count++;
                end else begin
                    want = luma_expected.pop_front();
                    if (gray_ch.gray !== want.gray) begin
                        $error("gray: expected %0d, got %0d", want.gray, gray_ch.gray);
                        fail_count++;
                    end
                    if (gray_ch.row_end !== want.row_end) begin
                        $error("row_end: expected %0b, got %0b", want.row_end, gray_ch.row_end);
                        fail_count++;
                    end
                    results_checked++;
                end
            end
            gray_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("watchdog expired after %0d cycles", CYCLE_LIMIT);
            $display("rgb_conv3x3_luma_filter test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Sampled just after the falling edge, so all edge activity has settled
    task automatic wait_drained(int gap);
        do @(negedge i_clk);
        while (pixel_queue.size() != 0 || pix_ch.valid || luma_expected.size() != 0);
        repeat (gap) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_FILTER_MODE: begin
                mode_reg = data[MODE_W-1:0];
                modes_seen[data[MODE_W-1:0]] = 1'b1;
            end
            CFG_WEIGHT_RED:   weight_reg[0] = data;
            CFG_WEIGHT_GREEN: weight_reg[1] = data;
            CFG_WEIGHT_BLUE:  weight_reg[2] = data;
            CFG_PADDED_WIDTH: width_reg = data[COL_W-1:0];
            default: ;
        endcase
        settings_count++;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Full register set, only once the pipe is empty
    task automatic configure(logic [MODE_W-1:0] m, logic [WEIGHT_W-1:0] wr,
                             logic [WEIGHT_W-1:0] wg, logic [WEIGHT_W-1:0] wb,
                             logic [COL_W-1:0] width);
        wait_drained(IDLE_GAP);
        write_reg(CFG_FILTER_MODE,  CFG_DATA_W'(m));
        write_reg(CFG_WEIGHT_RED,   wr);
        write_reg(CFG_WEIGHT_GREEN, wg);
        write_reg(CFG_WEIGHT_BLUE,  wb);
        write_reg(CFG_PADDED_WIDTH, CFG_DATA_W'(width));
    endtask

    // Biased toward 0 and full scale so clamping and flat areas turn up
    function automatic logic [PIX_W-1:0] pick_sample(bit extreme);
        if (extreme) return $urandom_range(0, 1) ? '1 : '0;
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return WEIGHT_W'($urandom_range(0, 255));
            default: return WEIGHT_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Queue n pixels; the first may open a frame, and with noise set a stray
    // frame start now and then breaks a frame part way through
    task automatic push_pixels(int n, bit start, bit extreme, bit noise);
        pixel_t p;
        int k;
        @(negedge i_clk);
        for (k = 0; k < n; k++) begin
            p.red         = pick_sample(extreme);
            p.green       = pick_sample(extreme);
            p.blue        = pick_sample(extreme);
            p.frame_start = (start && k == 0) ||
                            (noise && k > 0 && $urandom_range(0, 199) == 0);
            pixel_queue.push_back(p);
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int eff, n, rows, half, frames, f, phase, random_items;
        logic [MODE_W-1:0] m;
        logic [COL_W-1:0]  wr;

        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_FILTER_MODE;
        cfg_data           = '0;
        pix_ch.valid       = 1'b0;
        pix_ch.red         = '0;
        pix_ch.green       = '0;
        pix_ch.blue        = '0;
        pix_ch.frame_start = 1'b0;
        gray_ch.ready      = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: width below range (saturates to 3), full-scale weights,
        // pixels at 0 / 255 only. Two priming rows, then one row per kernel,
        // each row giving a single result on the last column.
        configure(MODE_MEAN, '1, '1, '1, 11'd1);
        push_pixels(6, 1'b1, 1'b1, 1'b0);
        push_pixels(3, 1'b0, 1'b1, 1'b0);
        wait_drained(IDLE_GAP);
        write_reg(CFG_FILTER_MODE, CFG_DATA_W'(MODE_GAUSS));
        push_pixels(3, 1'b0, 1'b1, 1'b0);
        wait_drained(IDLE_GAP);
        write_reg(CFG_FILTER_MODE, CFG_DATA_W'(MODE_HIGHPASS));
        push_pixels(3, 1'b0, 1'b1, 1'b0);
        wait_drained(IDLE_GAP);
        write_reg(CFG_FILTER_MODE, CFG_DATA_W'(MODE_LAPLACE));
        push_pixels(3, 1'b0, 1'b1, 1'b0);
        wait_drained(IDLE_GAP);
        write_reg(CFG_FILTER_MODE, CFG_DATA_W'(MODE_ZERO_HIGH));
        push_pixels(3, 1'b0, 1'b1, 1'b0);

        // Random: each phase picks a register set and an idling pattern, then
        // sends one or two well-formed frames, some cut short or broken
        phase        = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 4) == 0)
                m = MODE_W'($urandom_range(MODE_ZERO_LOW, MODE_ZERO_HIGH));
            else
                m = MODE_W'($urandom_range(MODE_MEAN, MODE_LAPLACE));
            case ($urandom_range(0, 9))
                0:       wr = COL_W'($urandom_range(0, 2));
                1:       wr = COL_W'($urandom_range(19, 40));
                default: wr = COL_W'($urandom_range(3, 12));
            endcase
            configure(m, pick_weight(), pick_weight(), pick_weight(), wr);
            eff = clamp_width(wr);

            @(negedge i_clk);
            case (phase % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 78; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 78; end
                default: begin src_idle_pct = 16; sink_stall_pct = 16; end
            endcase

            frames = $urandom_range(1, 2);
            for (f = 0; f < frames && random_items < RANDOM_ITEMS; f++) begin
                rows = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 6);
                n = rows * eff + $urandom_range(0, eff - 1);
                // the last frame is cut short to keep the pixel budget
                if (n > RANDOM_ITEMS - random_items) n = RANDOM_ITEMS - random_items;
                if (phase == 0 || $urandom_range(0, 3) == 0) begin
                    // hold the sender mid-frame until the output has caught up
                    half = (n + 1) / 2;
                    push_pixels(half, 1'b1, 1'b0, 1'b1);
                    wait_drained(0);
                    push_pixels(n - half, 1'b0, 1'b0, 1'b1);
                end else begin
                    push_pixels(n, 1'b1, 1'b0, 1'b1);
                end
                random_items += n;
            end
            phase++;
        end

        // Width narrowed while the column count is beyond the new last
        // column: the next pixel closes the row and the frame carries on
        configure(MODE_HIGHPASS, pick_weight(), pick_weight(), pick_weight(), 11'd12);
        @(negedge i_clk);
        src_idle_pct   = 16;
        sink_stall_pct = 16;
        push_pixels(3 * 12 + 8, 1'b1, 1'b0, 1'b0);
        wait_drained(IDLE_GAP);
        write_reg(CFG_PADDED_WIDTH, CFG_DATA_W'(5));
        push_pixels(3 * 5, 1'b0, 1'b0, 1'b0);

        // Register above range saturates to the full store: a long first row
        // stays open, then a narrow width closes it and the frame carries on
        configure(MODE_W'($urandom_range(MODE_MEAN, MODE_LAPLACE)),
                  pick_weight(), pick_weight(), pick_weight(), WIDTH_OVER);
        @(negedge i_clk);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        push_pixels(40, 1'b1, 1'b0, 1'b0);
        wait_drained(IDLE_GAP);
        write_reg(CFG_PADDED_WIDTH, CFG_DATA_W'(5));
        push_pixels(3 * 5 + 1, 1'b0, 1'b0, 1'b0);

        wait_drained(IDLE_GAP);
        $display("%0d pixel transactions in, %0d gray transactions checked",
                 pixels_in, results_checked);
        $display("%0d register writes over %0d random phases, filter modes used %b",
                 settings_count, phase, modes_seen);
        if (fail_count == 0)
            $display("rgb_conv3x3_luma_filter test passed");
        else
            $display("rgb_conv3x3_luma_filter test failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/rgbcf_pkg.sv
rtl/core/rgbcf_pix_if.sv
rtl/core/rgbcf_gray_if.sv
rtl/core/rgb_conv3x3_luma_filter.sv
tb/testbench.sv
